// ===== rtl/vertex_project_to_window_top_defines.svh =====
// Assertion macros for the vertex projection block.
// Used by the top level only; no other dependencies.
`ifndef VERTEX_PROJECT_TO_WINDOW_TOP_DEFINES_SVH
`define VERTEX_PROJECT_TO_WINDOW_TOP_DEFINES_SVH
`define VPW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Flags a condition that must never be seen outside reset.
`define VPW_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== rtl/vpw_pkg.sv =====
// Package for the vertex projection block: widths, codes and fixed-point helpers.
// No dependencies.
`default_nettype none
package vpw_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumCfg = 5;
  // Quotient magnitude bound after the divide.
  localparam int unsigned NdcLimLog = 46;
  localparam int unsigned QW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VP_X = 3'd0, CFG_VP_Y = 3'd1, CFG_VP_W = 3'd2, CFG_VP_H = 3'd3, CFG_EPS = 3'd4
  } cfg_idx_e;

  typedef enum logic {KIND_ELEM = 1'b0, KIND_POINT = 1'b1} kind_e;

  typedef struct packed {
    logic [CfgW-1:0] vp_x;
    logic [CfgW-1:0] vp_y;
    logic [CfgW-1:0] vp_w;
    logic [CfgW-1:0] vp_h;
    logic [CfgW-1:0] eps;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic              matrix_select;
    logic [1:0]        elem_row;
    logic [1:0]        elem_col;
    logic signed [31:0] elem_value;
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] win_z;
    logic               proj_ok;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [QW+17:0] x);
    logic signed [QW+17:0] mx, mn;
    mx = (QW+18)'(signed'(33'sh0_7FFF_FFFF));
    mn = -mx - (QW+18)'(1);
    if (x > mx) sat32 = 32'sh7FFF_FFFF;
    else if (x < mn) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/vpw_if.sv =====
// Valid/ready channel interfaces used by the vertex projection block.
// Depends on vpw_pkg for payload types.
`default_nettype none
interface vpw_in_if import vpw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vpw_out_if import vpw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vpw_cfg_if import vpw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/vpw_xform.sv =====
// One 4x4 matrix stage: four products per column, registered, then a summing stage.
// Depends on vpw_pkg. Two pipeline stages; advances when en_i is high.
`default_nettype none
module vpw_xform import vpw_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic signed [31:0] m_i [16],
  input  wire logic signed [31:0] v_i [4],
  output      logic signed [31:0] r_o [4]
);
  logic signed [63:0] prod_q [16];
  logic signed [31:0] r_q [4];

  // Products are floored by the arithmetic shift in the summing stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 16; k++) begin
        prod_q[k] <= 64'(m_i[k]) * 64'(v_i[k/4]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        r_q[j] <= sat32(66'(prod_q[j] >>> FracBits) + 66'(prod_q[4+j] >>> FracBits)
                      + 66'(prod_q[8+j] >>> FracBits) + 66'(prod_q[12+j] >>> FracBits));
      end
    end
  end
  assign r_o = r_q;
endmodule
`default_nettype wire

// ===== rtl/vpw_div.sv =====
// Pipelined restoring divider for |c| * 2^FracBits / |w|, one quotient bit per stage.
// Depends on vpw_pkg. Registered entry, quotient and clamp stages; advances when en_i is high.
`default_nettype none
module vpw_div import vpw_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic signed [31:0] c_i,
  input  wire logic signed [31:0] w_i,
  output      logic signed [QW:0] q_o
);
  // The dividend is never narrower than the quotient so every stage has a bit to bring down.
  localparam int unsigned NW = (32 + FracBits > QW) ? 32 + FracBits : QW;
  // Dividend bits above QW only feed a quotient that clamps anyway.
  logic [NW-1:0]  num_q [QW+1];
  logic [32:0]    rem_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic [31:0]    den_q [QW+1];
  logic           neg_q [QW+1];
  logic           big_q [QW+1];
  logic signed [QW:0] q_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [31:0] ac, aw;
      logic [NW-1:0] n;
      logic [32:0] r;
      logic b;
      ac = c_i[31] ? 32'(-c_i) : c_i;
      aw = w_i[31] ? 32'(-w_i) : w_i;
      n = NW'({ac, {FracBits{1'b0}}});
      // Leading dividend bits beyond the quotient width: any quotient bit
      // from them forces the clamp.
      r = '0;
      b = 1'b0;
      for (int k = int'(NW) - 1; k >= int'(QW); k--) begin
        r = {r[31:0], n[k]};
        if (r >= {1'b0, aw}) begin
          r = r - {1'b0, aw};
          b = 1'b1;
        end
      end
      num_q[0] <= n;
      den_q[0] <= aw;
      neg_q[0] <= c_i[31] ^ w_i[31];
      rem_q[0] <= r;
      quo_q[0] <= '0;
      big_q[0] <= b;
      for (int s = 0; s < QW; s++) begin
        logic [32:0] r2;
        logic bit_q;
        r2 = {rem_q[s][31:0], num_q[s][QW-1-s]};
        bit_q = r2 >= {1'b0, den_q[s]};
        if (bit_q) r2 = r2 - {1'b0, den_q[s]};
        rem_q[s+1] <= r2;
        quo_q[s+1] <= {quo_q[s][QW-2:0], bit_q};
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        big_q[s+1] <= big_q[s];
      end
      begin
        logic [QW:0] m;
        m = (big_q[QW] || quo_q[QW] > QW'(49'(1) << NdcLimLog))
            ? (QW+1)'(49'(1) << NdcLimLog) : {1'b0, quo_q[QW]};
        q_q <= neg_q[QW] ? -signed'(m) : signed'(m);
      end
    end
  end
  assign q_o = q_q;
endmodule
`default_nettype wire

// ===== rtl/vertex_project_to_window_top.sv =====
// Top level of the vertex projection block: matrix stores, two transform stages,
// three dividers and the viewport map. Depends on vpw_pkg, vpw_if, vpw_xform, vpw_div.
`default_nettype none
`include "vertex_project_to_window_top_defines.svh"
// A request can enter every cycle while the pipe is not held. A point's result
// passes the product and sum registers of each matrix stage, the divider's entry
// stage, a stage per quotient bit, the clamp, then the viewport map. All stages
// advance together and hold when the output register is full and not taken.
// Element writes take effect for points accepted after them and travel the pipe
// as bubbles. Configuration is read live, so write it only while the pipe is empty.
module vertex_project_to_window_top import vpw_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  vpw_in_if.sink   in_i,
  vpw_out_if.source out_o,
  vpw_cfg_if.sink  cfg_i
);
  localparam int unsigned Lat = 4 + QW + 1 + 1 + 2;
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  cfg_t cfg_q;
  logic signed [31:0] mv_q [16];
  logic signed [31:0] pj_q [16];
  logic [Lat-1:0] vld_q;
  logic en;
  logic in_acc;
  logic [1:0] pw_vld_q;
  logic [3:0] pw_idx_q [2];
  logic signed [31:0] pw_val_q [2];

  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;
  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{vp_x: '0, vp_y: '0, vp_w: 16'd640, vp_h: 16'd480, eps: 16'd1};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_VP_X: cfg_q.vp_x <= cfg_i.wdata[CfgW-1:0];
        CFG_VP_Y: cfg_q.vp_y <= cfg_i.wdata[CfgW-1:0];
        CFG_VP_W: cfg_q.vp_w <= cfg_i.wdata[CfgW-1:0];
        CFG_VP_H: cfg_q.vp_h <= cfg_i.wdata[CfgW-1:0];
        CFG_EPS:  cfg_q.eps  <= cfg_i.wdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Projection writes pass through pw_vld_q[0] and [1], so points still in the modelview
  // stage meet the projection matrix that was current when they entered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pw_vld_q <= '0;
    else if (en) pw_vld_q <= {pw_vld_q[0],
                              in_acc && in_i.data.kind == KIND_ELEM && in_i.data.matrix_select};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_idx_q[0] <= {in_i.data.elem_row, in_i.data.elem_col};
      pw_val_q[0] <= in_i.data.elem_value;
      pw_idx_q[1] <= pw_idx_q[0];
      pw_val_q[1] <= pw_val_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) begin
        mv_q[k] <= (k % 5 == 0) ? One : '0;
        pj_q[k] <= (k % 5 == 0) ? One : '0;
      end
    end else begin
      if (in_acc && in_i.data.kind == KIND_ELEM && !in_i.data.matrix_select)
        mv_q[{in_i.data.elem_row, in_i.data.elem_col}] <= in_i.data.elem_value;
      if (en && pw_vld_q[1])
        pj_q[pw_idx_q[1]] <= pw_val_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], in_acc && in_i.data.kind == KIND_POINT};
  end

  logic signed [31:0] obj [4];
  logic signed [31:0] eye [4];
  logic signed [31:0] clip [4];
  assign obj[0] = in_i.data.obj_x;
  assign obj[1] = in_i.data.obj_y;
  assign obj[2] = in_i.data.obj_z;
  assign obj[3] = One;

  vpw_xform #(.FracBits(FracBits)) u_mv (.clk_i, .en_i(en), .m_i(mv_q), .v_i(obj), .r_o(eye));
  vpw_xform #(.FracBits(FracBits)) u_pj (.clk_i, .en_i(en), .m_i(pj_q), .v_i(eye), .r_o(clip));

  logic signed [QW:0] ndc [3];
  for (genvar a = 0; a < 3; a++) begin : g_div
    vpw_div #(.FracBits(FracBits)) u_div (.clk_i, .en_i(en), .c_i(clip[a]), .w_i(clip[3]),
      .q_o(ndc[a]));
  end

  // Zero-w flag follows the divider delay alongside it.
  logic zw_q [QW+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [32:0] aw;
      aw = clip[3][31] ? 33'(-33'(clip[3])) : 33'(clip[3]);
      zw_q[0] <= (clip[3] == '0) || (aw < 33'(cfg_q.eps));
      for (int s = 0; s < QW; s++) zw_q[s+1] <= zw_q[s];
    end
  end

  // Map stage 1: scaled terms; stage 2: add origin and saturate, or zero for near-zero w.
  logic signed [QW+17:0] tx_q, ty_q;
  logic signed [QW:0] nz_q;
  logic zw1_q;
  logic zw2_q;
  out_item_t res_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= signed'({1'b0, cfg_q.vp_w}) * (QW+18)'(ndc[0] + (QW+1)'(One));
      ty_q <= signed'({1'b0, cfg_q.vp_h}) * (QW+18)'(ndc[1] + (QW+1)'(One));
      nz_q <= ndc[2] + (QW+1)'(One);
      zw1_q <= zw_q[QW];
      zw2_q <= zw1_q;
      if (zw2_q) begin
        res_q <= '{win_x: '0, win_y: '0, win_z: '0, proj_ok: 1'b0};
      end else begin
        res_q.win_x <= sat32((signed'((QW+18)'(cfg_q.vp_x)) <<< FracBits) + (tx_q >>> 1));
        res_q.win_y <= sat32((signed'((QW+18)'(cfg_q.vp_y)) <<< FracBits) + (ty_q >>> 1));
        res_q.win_z <= sat32((QW+18)'(nz_q >>> 1));
        res_q.proj_ok <= 1'b1;
      end
    end
  end

  assign out_o.valid = vld_q[Lat-1];
  assign out_o.data = res_q;

  `VPW_ASSERT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready |=> $stable(out_o.data), "result changed under stall")
  `VPW_ASSERT(a_ready_en, clk_i, rst_ni, !out_o.valid |-> in_i.ready, "input blocked with empty output")
  `VPW_ASSERT(a_fail_zero, clk_i, rst_ni, out_o.valid && !out_o.data.proj_ok |-> out_o.data.win_x == '0, "failed projection with nonzero x")
  `VPW_NEVER(a_valid_known, clk_i, rst_ni, $isunknown(out_o.valid), "unknown result valid")
endmodule
`default_nettype wire

// ===== tb/sv/vertex_project_to_window_top_tb.sv =====
// Testbench for vertex_project_to_window_top: random and directed point and matrix requests,
// checked against an in-bench fixed-point projection model. Depends on vpw_pkg and vpw_if.
`timescale 1ns / 1ps
module vertex_project_to_window_top_tb;
  import vpw_pkg::*;

  localparam int unsigned Frac = FracBitsDefault;
  localparam longint OneFx = longint'(1) <<< Frac;
  localparam longint NdcLim = longint'(1) <<< NdcLimLog;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  class projection_scoreboard;
    longint modelview[16];
    longint projection[16];
    longint vp_x, vp_y, vp_w, vp_h, eps;
    out_item_t expected_q[$];
    int errors;

    function new();
      for (int k = 0; k < 16; k++) begin
        modelview[k] = (k % 5 == 0) ? OneFx : 0;
        projection[k] = (k % 5 == 0) ? OneFx : 0;
      end
      vp_x = 0; vp_y = 0; vp_w = 640; vp_h = 480; eps = 1;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
      longint v;
      v = longint'(value[15:0]);
      case (idx)
        CFG_VP_X: vp_x = v;
        CFG_VP_Y: vp_y = v;
        CFG_VP_W: vp_w = v;
        CFG_VP_H: vp_h = v;
        CFG_EPS:  eps = v;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint divide_by_w(longint c, longint w);
      longint ac, aw, q;
      ac = (c < 0) ? -c : c;
      aw = (w < 0) ? -w : w;
      q = (ac <<< Frac) / aw;
      if (q > NdcLim) q = NdcLim;
      return ((c < 0) != (w < 0)) ? -q : q;
    endfunction

    function longint map_to_viewport(longint ndc, longint origin, longint size);
      return clamp32((origin <<< Frac) + ((size * (ndc + OneFx)) >>> 1));
    endfunction

    function void note_request(in_item_t it);
      longint obj[4], eye[4], clip[4];
      longint acc, w;
      out_item_t r;
      if (it.kind == KIND_ELEM) begin
        if (it.matrix_select) projection[{it.elem_row, it.elem_col}] = longint'(it.elem_value);
        else modelview[{it.elem_row, it.elem_col}] = longint'(it.elem_value);
        return;
      end
      obj[0] = longint'(it.obj_x);
      obj[1] = longint'(it.obj_y);
      obj[2] = longint'(it.obj_z);
      obj[3] = OneFx;
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += (modelview[i*4+j] * obj[i]) >>> Frac;
        eye[j] = clamp32(acc);
      end
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += (projection[i*4+j] * eye[i]) >>> Frac;
        clip[j] = clamp32(acc);
      end
      w = clip[3];
      if (w == 0 || (w > -eps && w < eps)) begin
        r = '0;
      end else begin
        r.win_x = 32'(map_to_viewport(divide_by_w(clip[0], w), vp_x, vp_w));
        r.win_y = 32'(map_to_viewport(divide_by_w(clip[1], w), vp_y, vp_h));
        r.win_z = 32'(clamp32((divide_by_w(clip[2], w) + OneFx) >>> 1));
        r.proj_ok = 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.win_x !== exp_r.win_x) begin
        $display("%0t: win_x expected %h actual %h", $time, exp_r.win_x, got.win_x);
        errors++;
      end
      if (got.win_y !== exp_r.win_y) begin
        $display("%0t: win_y expected %h actual %h", $time, exp_r.win_y, got.win_y);
        errors++;
      end
      if (got.win_z !== exp_r.win_z) begin
        $display("%0t: win_z expected %h actual %h", $time, exp_r.win_z, got.win_z);
        errors++;
      end
      if (got.proj_ok !== exp_r.proj_ok) begin
        $display("%0t: proj_ok expected %b actual %b", $time, exp_r.proj_ok, got.proj_ok);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  vpw_in_if  in_ch();
  vpw_out_if out_ch();
  vpw_cfg_if cfg_ch();

  vertex_project_to_window_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  projection_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit recv_hold;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("vertex_project_to_window_top_tb: FAIL");
    $finish;
  end

  // Receiver readiness changes on the falling edge only.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  function automatic logic [31:0] rand_fx();
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2 << Frac)) - (1 <<< Frac));
      default: return 32'($signed($urandom_range(8 << Frac)) - (4 <<< Frac));
    endcase
  endfunction

  task automatic send_request(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(it);
  endtask

  task automatic write_matrix(bit sel, int row, int col, logic [31:0] value);
    in_item_t it;
    it = '0;
    it.kind = KIND_ELEM;
    it.matrix_select = sel;
    it.elem_row = 2'(row);
    it.elem_col = 2'(col);
    it.elem_value = value;
    it.obj_x = $urandom;
    it.obj_y = $urandom;
    it.obj_z = $urandom;
    send_request(it);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it.kind = KIND_POINT;
    it.matrix_select = 1'($urandom_range(1));
    it.elem_row = 2'($urandom);
    it.elem_col = 2'($urandom);
    it.elem_value = $urandom;
    it.obj_x = x;
    it.obj_y = y;
    it.obj_z = z;
    send_request(it);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] value);
    logic [31:0] wd;
    wd = {16'($urandom), value};
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.wdata = wd;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, wd);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Element writes give no result, so allow the pipe to empty after the last result.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_viewport(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                              logic [15:0] h, logic [15:0] e);
    write_reg(CFG_VP_X, x);
    write_reg(CFG_VP_Y, y);
    write_reg(CFG_VP_W, w);
    write_reg(CFG_VP_H, h);
    write_reg(CFG_EPS, e);
    write_reg(CfgIdxSpare, 16'($urandom));
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 20)
        write_matrix(1'($urandom_range(1)), $urandom_range(3), $urandom_range(3), rand_fx());
      else
        send_point(rand_fx(), rand_fx(), rand_fx());
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_VP_X;
    cfg_ch.wdata = '0;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, identity transforms, field extremes.
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    // Clip w forced to zero, then restored.
    write_matrix(1, 3, 3, 32'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    // Perspective-like: w taken from -z, modelview with extreme element.
    write_matrix(1, 2, 3, 32'hFFFF_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFE_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
    write_matrix(0, 0, 0, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000);
    write_matrix(0, 0, 0, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000);
    write_matrix(0, 0, 0, 32'h0001_0000);
    write_matrix(1, 2, 3, 32'h0);
    write_matrix(1, 3, 3, 32'h0001_0000);
    drain();

    // Largest viewport, zero epsilon exercises the exact-zero w case.
    set_viewport(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0);
    write_matrix(1, 3, 3, 32'h0);
    send_point(32'h0001_0000, 32'h0, 32'h0);
    write_matrix(1, 3, 3, 32'h0000_0001);
    send_point(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    write_matrix(1, 3, 3, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    random_phase(300);
    drain();

    // Smallest viewport, large epsilon; sender idles often.
    set_viewport(16'h0, 16'h0, 16'h0001, 16'h0001, 16'hFFFF);
    send_idle_pct = 85;
    random_phase(300);
    drain();

    // Receiver stalls often, with one long hold while requests keep coming.
    set_viewport(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 85;
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      random_phase(300);
    join
    drain();

    set_viewport(16'($urandom), 16'($urandom), 16'($urandom_range(1, 2048)),
                 16'($urandom_range(1, 2048)), 16'($urandom_range(0, 64)));
    send_idle_pct = 25;
    recv_stall_pct = 25;
    random_phase(300);
    drain();

    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %h actual none",
               $time, sb.expected_q.size(), sb.expected_q[0]);
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("vertex_project_to_window_top_tb: PASS");
    end else begin
      $display("vertex_project_to_window_top_tb: FAIL");
    end
    $finish;
  end
endmodule
